FILE: hdl/tdr_pkg.sv
`default_nettype none
package tdr_pkg;

    // Frame size, row-major pixel order.
    localparam int FB_WIDTH  = 128;
    localparam int FB_HEIGHT = 128;
    localparam int PIXELS    = FB_WIDTH * FB_HEIGHT;
    localparam int ADDR_W    = $clog2(PIXELS);
    localparam int ROW_W     = $clog2(FB_HEIGHT + 1);
    localparam int COL_W     = $clog2(FB_WIDTH + 1);

    // Field widths of one beat.
    localparam int OP_W     = 2;
    localparam int CRD_W    = 16;
    localparam int GRAY_W   = 8;
    localparam int RADDR_W  = 14;
    localparam int DEPTH_W  = 17;
    localparam int COUNT_W  = 15;
    localparam int S_DATA_W = 168;
    localparam int M_DATA_W = 40;

    // Fixed-point arithmetic: 16 fraction bits, 48-bit accumulators.
    localparam int FRAC_W    = 16;
    localparam int ACC_W     = 48;
    localparam int OPB_W     = 20;
    localparam int XW        = OPB_W;
    localparam int DIVN_W    = 40;
    localparam int CNT_W     = 6;
    localparam int MUL_STEPS = OPB_W;
    localparam int DIV_STEPS = DIVN_W;

    localparam logic [DEPTH_W-1:0] DEPTH_EMPTY = 17'h10000;

    localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
    localparam logic [OP_W-1:0] OP_DRAW  = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;

    // Command to the shared multiply/divide unit.
    typedef struct packed {
        logic start;
        logic is_div;
    } tdr_cmd_t;

    // Status back from the shared unit.
    typedef struct packed {
        logic busy;
        logic done;
    } tdr_sts_t;

endpackage
`default_nettype wire

FILE: hdl/triangle_depth_rasterizer.sv
`default_nettype none
// Channel   Dir  Width  Beat contents
// s_*       in   168+2  one command: op in tuser, vertices, gray and read address in tdata
// m_*       out  40     one result: pixels written, read gray, read depth
//
// Every accepted beat gives exactly one result beat.
// Steps: a read goes through the read and read-wait states, a depth clear writes
// every depth once. A draw runs the x and z edge-step divides in the shared unit, the
// start-row multiplies per non-empty half, the span-depth divide per visible row
// (with a multiply more when the span is clipped on the left) and, per visible
// pixel, the depth read and then the test and write.
// Reset starts a pass that sets every depth to empty and every gray
// to zero; s_tready stays low until it ends. s_tready is high only when idle,
// and a finished result may wait in the output register while the next beat is
// taken; the sequencer stalls only if a second result is ready before it.
module triangle_depth_rasterizer
    import tdr_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    // ax_in, ay_in, az_in, bx_in, by_in, bz_in, cx_in, cy_in, cz_in, gray,
    // read_addr, two zero pad bits
    input  logic [S_DATA_W-1:0] s_tdata,
    // op
    input  logic [OP_W-1:0]     s_tuser,
    output logic                m_tvalid,
    input  logic                m_tready,
    // pixels_written, read_gray, read_depth
    output logic [M_DATA_W-1:0] m_tdata
);

    // One-hot sequencer states.
    typedef enum logic [13:0] {
        ST_CLEAR = 14'b00000000000001,
        ST_IDLE  = 14'b00000000000010,
        ST_RD    = 14'b00000000000100,
        ST_RDW   = 14'b00000000001000,
        ST_STEP  = 14'b00000000010000,
        ST_HALF  = 14'b00000000100000,
        ST_HINIT = 14'b00000001000000,
        ST_ROW   = 14'b00000010000000,
        ST_SDIV  = 14'b00000100000000,
        ST_SMUL  = 14'b00001000000000,
        ST_PRD   = 14'b00010000000000,
        ST_PWR   = 14'b00100000000000,
        ST_NEXT  = 14'b01000000000000,
        ST_DONE  = 14'b10000000000000
    } state_t;

    // Truncates a 32.16 edge position toward zero to a whole column.
    function automatic logic signed [XW-1:0] edge_col(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] q;
        q = v >>> FRAC_W;
        if (v[ACC_W-1] && (v[FRAC_W-1:0] != '0))
            q = q + 1'b1;
        return q[XW-1:0];
    endfunction

    // Depth in LSB units with 16 fraction bits to a stored depth, saturated.
    function automatic logic [15:0] depth_of(input logic signed [ACC_W-1:0] v);
        logic [15:0] d;
        if (v[ACC_W-1])
            d = '0;
        else if (v[ACC_W-2:FRAC_W+16] != '0)
            d = 16'hFFFF;
        else
            d = v[FRAC_W+15:FRAC_W];
        return d;
    endfunction

    // Sign- or zero-extends a coordinate and scales it by one in 32.16.
    function automatic logic signed [ACC_W-1:0] fx_of(input logic [CRD_W-1:0] v,
                                                       input logic is_signed);
        logic signed [ACC_W-1:0] e;
        e = {{(ACC_W-CRD_W){is_signed & v[CRD_W-1]}}, v};
        return e <<< FRAC_W;
    endfunction

    state_t                  state_reg, state_next;
    logic [ADDR_W-1:0]       clr_cnt_reg, clr_cnt_next;
    logic                    clr_color_reg, clr_color_next;
    logic signed [CRD_W-1:0] vx_reg [3];
    logic signed [CRD_W-1:0] vy_reg [3];
    logic [CRD_W-1:0]        vz_reg [3];
    logic signed [CRD_W-1:0] vx_next [3];
    logic signed [CRD_W-1:0] vy_next [3];
    logic [CRD_W-1:0]        vz_next [3];
    logic [GRAY_W-1:0]       gray_reg, gray_next;
    logic [RADDR_W-1:0]      rd_addr_reg, rd_addr_next;
    logic [2:0]              k_reg, k_next;
    logic                    half_reg, half_next;
    logic                    wait_reg, wait_next;
    logic                    go_reg, go_next;
    logic                    div_sel_reg, div_sel_next;
    logic signed [ACC_W-1:0] opa_reg, opa_next;
    logic [OPB_W-1:0]        opb_reg, opb_next;
    logic signed [ACC_W-1:0] step_reg [6];
    logic signed [ACC_W-1:0] step_next [6];
    logic signed [ACC_W-1:0] acc_reg [4];
    logic signed [ACC_W-1:0] acc_next [4];
    logic [ROW_W-1:0]        row_reg, row_next;
    logic [ROW_W-1:0]        row_hi_reg, row_hi_next;
    logic [OPB_W-1:0]        a0_reg, a0_next;
    logic [OPB_W-1:0]        b0_reg, b0_next;
    logic [COL_W-1:0]        col_reg, col_next;
    logic [COL_W-1:0]        col_hi_reg, col_hi_next;
    logic signed [ACC_W-1:0] zv_reg, zv_next;
    logic signed [ACC_W-1:0] zspan_reg, zspan_next;
    logic [OPB_W-1:0]        neg_off_reg, neg_off_next;
    logic                    ax_neg_reg, ax_neg_next;
    logic [COUNT_W-1:0]      count_reg, count_next;
    logic [GRAY_W-1:0]       res_gray_reg, res_gray_next;
    logic [DEPTH_W-1:0]      res_depth_reg, res_depth_next;
    logic                    m_valid_reg, m_valid_next;
    logic [M_DATA_W-1:0]     m_data_reg, m_data_next;

    // Depth and gray stores, one write and one registered read per cycle.
    logic [DEPTH_W-1:0]      depth_mem [PIXELS];
    logic [GRAY_W-1:0]       color_mem [PIXELS];
    logic [DEPTH_W-1:0]      depth_rd_reg;
    logic [GRAY_W-1:0]       color_rd_reg;
    logic                    dwe, cwe;
    logic [ADDR_W-1:0]       waddr, raddr, pix_idx;
    logic [DEPTH_W-1:0]      wdepth;
    logic [GRAY_W-1:0]       wcolor;

    tdr_cmd_t                cmd;
    tdr_sts_t                sts;
    logic signed [ACC_W-1:0] unit_res;

    // Input unpacking and vertex sort by row.
    logic [OP_W-1:0]         in_op;
    logic signed [CRD_W-1:0] in_x [3];
    logic signed [CRD_W-1:0] in_y [3];
    logic [CRD_W-1:0]        in_z [3];
    logic [GRAY_W-1:0]       in_gray;
    logic [RADDR_W-1:0]      in_raddr;
    logic signed [CRD_W-1:0] sx [3];
    logic signed [CRD_W-1:0] sy [3];
    logic [CRD_W-1:0]        sz [3];
    logic signed [CRD_W-1:0] tx, ty;
    logic [CRD_W-1:0]        tz;

    // Edge-step operands for the current step index.
    logic signed [CRD_W:0]   st_delta, st_dy;
    // Half setup.
    logic signed [CRD_W:0]   h_ylo, h_yhi, h_lo, h_hi;
    logic signed [CRD_W+1:0] h_a0, h_b0;
    // Start-row multiply operands.
    logic signed [ACC_W-1:0] hi_mcand, hi_base;
    logic [OPB_W-1:0]        hi_mplier;
    // Span setup.
    logic signed [XW-1:0]    e_xa, e_xb, s_ax, s_bx, s_lo, s_hi;
    logic signed [ACC_W-1:0] s_az, s_bz;
    logic signed [XW:0]      s_wdt;
    logic [15:0]             pix_d;
    logic                    pix_pass;

    assign in_op    = s_tuser;
    assign in_gray  = s_tdata[151:144];
    assign in_raddr = s_tdata[165:152];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            in_x[i] = s_tdata[48*i +: CRD_W];
            in_y[i] = s_tdata[48*i+16 +: CRD_W];
            in_z[i] = s_tdata[48*i+32 +: CRD_W];
            sx[i] = in_x[i];
            sy[i] = in_y[i];
            sz[i] = in_z[i];
        end
        tx = '0;
        ty = '0;
        tz = '0;
        // Three compare-swaps with strict less than sort the vertices by row.
        if (sy[1] < sy[0])
        begin
            tx = sx[0]; ty = sy[0]; tz = sz[0];
            sx[0] = sx[1]; sy[0] = sy[1]; sz[0] = sz[1];
            sx[1] = tx; sy[1] = ty; sz[1] = tz;
        end
        if (sy[2] < sy[0])
        begin
            tx = sx[0]; ty = sy[0]; tz = sz[0];
            sx[0] = sx[2]; sy[0] = sy[2]; sz[0] = sz[2];
            sx[2] = tx; sy[2] = ty; sz[2] = tz;
        end
        if (sy[2] < sy[1])
        begin
            tx = sx[1]; ty = sy[1]; tz = sz[1];
            sx[1] = sx[2]; sy[1] = sy[2]; sz[1] = sz[2];
            sx[2] = tx; sy[2] = ty; sz[2] = tz;
        end
    end

    // Edge steps: x1 and z1 use the first and second vertex, x2 and z2 the first
    // and third, x3 and z3 the second and third.
    always_comb
    begin
        st_delta = '0;
        st_dy    = '0;
        case (k_reg)
            3'd0:
            begin
                st_delta = {vx_reg[1][CRD_W-1], vx_reg[1]} - {vx_reg[0][CRD_W-1], vx_reg[0]};
                st_dy    = {vy_reg[1][CRD_W-1], vy_reg[1]} - {vy_reg[0][CRD_W-1], vy_reg[0]};
            end
            3'd1:
            begin
                st_delta = {1'b0, vz_reg[1]} - {1'b0, vz_reg[0]};
                st_dy    = {vy_reg[1][CRD_W-1], vy_reg[1]} - {vy_reg[0][CRD_W-1], vy_reg[0]};
            end
            3'd2:
            begin
                st_delta = {vx_reg[2][CRD_W-1], vx_reg[2]} - {vx_reg[0][CRD_W-1], vx_reg[0]};
                st_dy    = {vy_reg[2][CRD_W-1], vy_reg[2]} - {vy_reg[0][CRD_W-1], vy_reg[0]};
            end
            3'd3:
            begin
                st_delta = {1'b0, vz_reg[2]} - {1'b0, vz_reg[0]};
                st_dy    = {vy_reg[2][CRD_W-1], vy_reg[2]} - {vy_reg[0][CRD_W-1], vy_reg[0]};
            end
            3'd4:
            begin
                st_delta = {vx_reg[2][CRD_W-1], vx_reg[2]} - {vx_reg[1][CRD_W-1], vx_reg[1]};
                st_dy    = {vy_reg[2][CRD_W-1], vy_reg[2]} - {vy_reg[1][CRD_W-1], vy_reg[1]};
            end
            3'd5:
            begin
                st_delta = {1'b0, vz_reg[2]} - {1'b0, vz_reg[1]};
                st_dy    = {vy_reg[2][CRD_W-1], vy_reg[2]} - {vy_reg[1][CRD_W-1], vy_reg[1]};
            end
            default:
            begin
                st_delta = '0;
                st_dy    = '0;
            end
        endcase
    end

    // Row range of the current half and the row offsets from its start vertices.
    always_comb
    begin
        h_ylo = half_reg ? {vy_reg[1][CRD_W-1], vy_reg[1]} : {vy_reg[0][CRD_W-1], vy_reg[0]};
        h_yhi = half_reg ? {vy_reg[2][CRD_W-1], vy_reg[2]} : {vy_reg[1][CRD_W-1], vy_reg[1]};
        h_lo  = h_ylo[CRD_W] ? '0 : h_ylo;
        h_hi  = (h_yhi > (CRD_W+1)'(FB_HEIGHT)) ? (CRD_W+1)'(FB_HEIGHT) : h_yhi;
        h_a0  = {h_lo[CRD_W], h_lo} - {h_ylo[CRD_W], h_ylo};
        h_b0  = {h_lo[CRD_W], h_lo} - {vy_reg[0][CRD_W-1], vy_reg[0][CRD_W-1], vy_reg[0]};
    end

    // Start-row products: short-edge column, long-edge column, short-edge depth,
    // long-edge depth. The long edge always runs from the first vertex.
    always_comb
    begin
        hi_mcand  = '0;
        hi_base   = '0;
        hi_mplier = '0;
        case (k_reg)
            3'd0:
            begin
                hi_mcand  = half_reg ? step_reg[4] : step_reg[0];
                hi_base   = fx_of(half_reg ? vx_reg[1] : vx_reg[0], 1'b1);
                hi_mplier = a0_reg;
            end
            3'd1:
            begin
                hi_mcand  = step_reg[2];
                hi_base   = fx_of(vx_reg[0], 1'b1);
                hi_mplier = b0_reg;
            end
            3'd2:
            begin
                hi_mcand  = half_reg ? step_reg[5] : step_reg[1];
                hi_base   = fx_of(half_reg ? vz_reg[1] : vz_reg[0], 1'b0);
                hi_mplier = a0_reg;
            end
            3'd3:
            begin
                hi_mcand  = step_reg[3];
                hi_base   = fx_of(vz_reg[0], 1'b0);
                hi_mplier = b0_reg;
            end
            default:
            begin
                hi_mcand  = '0;
                hi_base   = '0;
                hi_mplier = '0;
            end
        endcase
    end

    // Span of the current row, ordered left to right and clipped to the frame.
    always_comb
    begin
        e_xa = edge_col(acc_reg[0]);
        e_xb = edge_col(acc_reg[1]);
        if (e_xa > e_xb)
        begin
            s_ax = e_xb;
            s_bx = e_xa;
            s_az = acc_reg[3];
            s_bz = acc_reg[2];
        end
        else
        begin
            s_ax = e_xa;
            s_bx = e_xb;
            s_az = acc_reg[2];
            s_bz = acc_reg[3];
        end
        s_wdt = {s_bx[XW-1], s_bx} - {s_ax[XW-1], s_ax};
        s_lo  = s_ax[XW-1] ? '0 : s_ax;
        s_hi  = (s_bx > XW'(FB_WIDTH)) ? XW'(FB_WIDTH) : s_bx;
    end

    assign pix_idx  = ADDR_W'(int'(row_reg) * FB_WIDTH + int'(col_reg));
    assign pix_d    = depth_of(zv_reg);
    assign pix_pass = ({1'b0, pix_d} < depth_rd_reg);

    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        clr_color_next = clr_color_reg;
        vx_next        = vx_reg;
        vy_next        = vy_reg;
        vz_next        = vz_reg;
        gray_next      = gray_reg;
        rd_addr_next   = rd_addr_reg;
        k_next         = k_reg;
        half_next      = half_reg;
        wait_next      = wait_reg;
        go_next        = 1'b0;
        div_sel_next   = div_sel_reg;
        opa_next       = opa_reg;
        opb_next       = opb_reg;
        step_next      = step_reg;
        acc_next       = acc_reg;
        row_next       = row_reg;
        row_hi_next    = row_hi_reg;
        a0_next        = a0_reg;
        b0_next        = b0_reg;
        col_next       = col_reg;
        col_hi_next    = col_hi_reg;
        zv_next        = zv_reg;
        zspan_next     = zspan_reg;
        neg_off_next   = neg_off_reg;
        ax_neg_next    = ax_neg_reg;
        count_next     = count_reg;
        res_gray_next  = res_gray_reg;
        res_depth_next = res_depth_reg;
        m_data_next    = m_data_reg;
        m_valid_next   = m_valid_reg && !m_tready;

        dwe    = 1'b0;
        cwe    = 1'b0;
        waddr  = pix_idx;
        raddr  = pix_idx;
        wdepth = {1'b0, pix_d};
        wcolor = gray_reg;

        case (state_reg)
            ST_CLEAR:
            begin
                dwe    = 1'b1;
                cwe    = clr_color_reg;
                waddr  = clr_cnt_reg;
                wdepth = DEPTH_EMPTY;
                wcolor = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == ADDR_W'(PIXELS - 1))
                begin
                    clr_color_next = 1'b0;
                    // The pass after reset gives no result; a clear command does.
                    state_next = clr_color_reg ? ST_IDLE : ST_DONE;
                end
            end
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    vx_next        = sx;
                    vy_next        = sy;
                    vz_next        = sz;
                    gray_next      = in_gray;
                    rd_addr_next   = in_raddr;
                    count_next     = '0;
                    res_gray_next  = '0;
                    res_depth_next = '0;
                    k_next         = '0;
                    half_next      = 1'b0;
                    wait_next      = 1'b0;
                    case (in_op)
                        OP_CLEAR:
                        begin
                            clr_cnt_next   = '0;
                            clr_color_next = 1'b0;
                            state_next     = ST_CLEAR;
                        end
                        OP_DRAW:
                            state_next = ST_STEP;
                        OP_READ:
                        begin
                            if ({1'b0, in_raddr} < (RADDR_W+1)'(PIXELS))
                                state_next = ST_RD;
                            else
                            begin
                                res_depth_next = DEPTH_EMPTY;
                                state_next     = ST_DONE;
                            end
                        end
                        default:
                            state_next = ST_DONE;
                    endcase
                end
            end
            ST_RD:
            begin
                raddr      = rd_addr_reg[ADDR_W-1:0];
                state_next = ST_RDW;
            end
            ST_RDW:
            begin
                res_gray_next  = color_rd_reg;
                res_depth_next = depth_rd_reg;
                state_next     = ST_DONE;
            end
            ST_STEP:
            begin
                if (!wait_reg)
                begin
                    go_next      = 1'b1;
                    div_sel_next = 1'b1;
                    opa_next     = {{(ACC_W-CRD_W-1){st_delta[CRD_W]}}, st_delta} <<< FRAC_W;
                    opb_next     = {{(OPB_W-CRD_W-1){1'b0}}, st_dy};
                    wait_next    = 1'b1;
                end
                else if (sts.done)
                begin
                    step_next[k_reg] = unit_res;
                    wait_next        = 1'b0;
                    if (k_reg == 3'd5)
                    begin
                        half_next  = 1'b0;
                        state_next = ST_HALF;
                    end
                    else
                        k_next = k_reg + 1'b1;
                end
            end
            ST_HALF:
            begin
                if (h_lo >= h_hi)
                begin
                    if (half_reg)
                        state_next = ST_DONE;
                    else
                        half_next = 1'b1;
                end
                else
                begin
                    row_next    = h_lo[ROW_W-1:0];
                    row_hi_next = h_hi[ROW_W-1:0];
                    a0_next     = {{(OPB_W-CRD_W-1){1'b0}}, h_a0[CRD_W:0]};
                    b0_next     = {{(OPB_W-CRD_W-1){1'b0}}, h_b0[CRD_W:0]};
                    k_next      = '0;
                    wait_next   = 1'b0;
                    state_next  = ST_HINIT;
                end
            end
            ST_HINIT:
            begin
                if (!wait_reg)
                begin
                    go_next      = 1'b1;
                    div_sel_next = 1'b0;
                    opa_next     = hi_mcand;
                    opb_next     = hi_mplier;
                    wait_next    = 1'b1;
                end
                else if (sts.done)
                begin
                    acc_next[k_reg[1:0]] = hi_base + unit_res;
                    wait_next            = 1'b0;
                    if (k_reg == 3'd3)
                        state_next = ST_ROW;
                    else
                        k_next = k_reg + 1'b1;
                end
            end
            ST_ROW:
            begin
                if (s_lo < s_hi)
                begin
                    col_next     = s_lo[COL_W-1:0];
                    col_hi_next  = s_hi[COL_W-1:0];
                    zv_next      = s_az;
                    ax_neg_next  = s_ax[XW-1];
                    neg_off_next = -s_ax;
                    go_next      = 1'b1;
                    div_sel_next = 1'b1;
                    opa_next     = s_bz - s_az;
                    opb_next     = s_wdt[OPB_W-1:0];
                    state_next   = ST_SDIV;
                end
                else
                    state_next = ST_NEXT;
            end
            ST_SDIV:
            begin
                if (sts.done)
                begin
                    zspan_next = unit_res;
                    if (ax_neg_reg)
                    begin
                        // Span starts left of the frame: move depth to column 0.
                        go_next      = 1'b1;
                        div_sel_next = 1'b0;
                        opa_next     = unit_res;
                        opb_next     = neg_off_reg;
                        state_next   = ST_SMUL;
                    end
                    else
                        state_next = ST_PRD;
                end
            end
            ST_SMUL:
            begin
                if (sts.done)
                begin
                    zv_next    = zv_reg + unit_res;
                    state_next = ST_PRD;
                end
            end
            ST_PRD:
                state_next = ST_PWR;
            ST_PWR:
            begin
                if (pix_pass)
                begin
                    dwe        = 1'b1;
                    cwe        = 1'b1;
                    count_next = count_reg + 1'b1;
                end
                zv_next  = zv_reg + zspan_reg;
                col_next = col_reg + 1'b1;
                if (col_reg + 1'b1 == col_hi_reg)
                    state_next = ST_NEXT;
                else
                    state_next = ST_PRD;
            end
            ST_NEXT:
            begin
                acc_next[0] = acc_reg[0] + (half_reg ? step_reg[4] : step_reg[0]);
                acc_next[1] = acc_reg[1] + step_reg[2];
                acc_next[2] = acc_reg[2] + (half_reg ? step_reg[5] : step_reg[1]);
                acc_next[3] = acc_reg[3] + step_reg[3];
                row_next    = row_reg + 1'b1;
                if (row_reg + 1'b1 == row_hi_reg)
                begin
                    if (half_reg)
                        state_next = ST_DONE;
                    else
                    begin
                        half_next  = 1'b1;
                        state_next = ST_HALF;
                    end
                end
                else
                    state_next = ST_ROW;
            end
            ST_DONE:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = {res_depth_reg, res_gray_reg, count_reg};
                    state_next   = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            clr_color_reg <= 1'b1;
            k_reg         <= '0;
            half_reg      <= 1'b0;
            wait_reg      <= 1'b0;
            go_reg        <= 1'b0;
            m_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            clr_color_reg <= clr_color_next;
            k_reg         <= k_next;
            half_reg      <= half_next;
            wait_reg      <= wait_next;
            go_reg        <= go_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        vx_reg        <= vx_next;
        vy_reg        <= vy_next;
        vz_reg        <= vz_next;
        gray_reg      <= gray_next;
        rd_addr_reg   <= rd_addr_next;
        div_sel_reg   <= div_sel_next;
        opa_reg       <= opa_next;
        opb_reg       <= opb_next;
        step_reg      <= step_next;
        acc_reg       <= acc_next;
        row_reg       <= row_next;
        row_hi_reg    <= row_hi_next;
        a0_reg        <= a0_next;
        b0_reg        <= b0_next;
        col_reg       <= col_next;
        col_hi_reg    <= col_hi_next;
        zv_reg        <= zv_next;
        zspan_reg     <= zspan_next;
        neg_off_reg   <= neg_off_next;
        ax_neg_reg    <= ax_neg_next;
        count_reg     <= count_next;
        res_gray_reg  <= res_gray_next;
        res_depth_reg <= res_depth_next;
        m_data_reg    <= m_data_next;
    end

    always_ff @(posedge clk)
    begin
        if (dwe)
            depth_mem[waddr] <= wdepth;
        if (cwe)
            color_mem[waddr] <= wcolor;
        depth_rd_reg <= depth_mem[raddr];
        color_rd_reg <= color_mem[raddr];
    end

    assign cmd.start  = go_reg;
    assign cmd.is_div = div_sel_reg;

    tdr_arith u_arith (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .op_a   (opa_reg),
        .op_b   (opb_reg),
        .sts    (sts),
        .result (unit_res)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule
`default_nettype wire

FILE: hdl/tdr_arith.sv
`default_nettype none
// Shared sequential unit: signed-by-unsigned shift-add multiply, one multiplier
// bit per cycle, or signed-by-unsigned restoring divide truncated toward zero,
// one quotient bit per cycle. A zero divisor gives a zero quotient.
module tdr_arith
    import tdr_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  tdr_cmd_t                cmd,
    input  logic signed [ACC_W-1:0] op_a,
    input  logic [OPB_W-1:0]        op_b,
    output tdr_sts_t                sts,
    output logic signed [ACC_W-1:0] result
);

    logic                    busy_reg;
    logic                    done_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic                    div_reg;
    logic                    neg_reg;
    logic                    zero_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] sh_reg;
    logic [OPB_W-1:0]        b_reg;
    logic [OPB_W-1:0]        rem_reg;

    logic [OPB_W:0]          rem_sh;
    logic [OPB_W:0]          rem_dif;
    logic                    fits;
    logic signed [ACC_W-1:0] mag_a;

    always_comb
    begin
        rem_sh  = {rem_reg, sh_reg[DIVN_W-1]};
        rem_dif = rem_sh - {1'b0, b_reg};
        fits    = (rem_sh >= {1'b0, b_reg});
        mag_a   = op_a[ACC_W-1] ? -op_a : op_a;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cmd.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= cmd.is_div ? CNT_W'(DIV_STEPS) : CNT_W'(MUL_STEPS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            div_reg  <= cmd.is_div;
            neg_reg  <= op_a[ACC_W-1];
            zero_reg <= (op_b == '0);
            b_reg    <= op_b;
            rem_reg  <= '0;
            acc_reg  <= '0;
            if (cmd.is_div)
                sh_reg <= {{(ACC_W-DIVN_W){1'b0}}, mag_a[DIVN_W-1:0]};
            else
                sh_reg <= op_a;
        end
        else if (busy_reg)
        begin
            if (div_reg)
            begin
                rem_reg <= fits ? rem_dif[OPB_W-1:0] : rem_sh[OPB_W-1:0];
                acc_reg <= {acc_reg[ACC_W-2:0], fits};
                sh_reg  <= sh_reg <<< 1;
            end
            else
            begin
                if (b_reg[0])
                    acc_reg <= acc_reg + sh_reg;
                sh_reg <= sh_reg <<< 1;
                b_reg  <= b_reg >> 1;
            end
        end
    end

    always_comb
    begin
        if (div_reg && zero_reg)
            result = '0;
        else if (div_reg && neg_reg)
            result = -acc_reg;
        else
            result = acc_reg;
        sts.busy = busy_reg;
        sts.done = done_reg;
    end

endmodule
`default_nettype wire

FILE: hdl/tdr_checker.sv
`default_nettype none
module tdr_checker
    import tdr_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    input  logic                s_tready,
    input  logic                m_tvalid,
    input  logic                m_tready,
    input  logic [M_DATA_W-1:0] m_tdata
);

    // A result that is not taken stays put.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // The block works on one command at a time.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second beat accepted while busy");

    // A new result appears only at the end of work, never straight from idle.
    a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("result without work");

    // A result that counts written pixels has its read gray and read depth clear,
    // depth never exceeds empty, and the count never exceeds the frame.
    a_result_fields: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[14:0] <= 15'd16384)
                  && !(m_tdata[39] && (m_tdata[38:23] != 16'd0))
                  && !((m_tdata[14:0] != 15'd0) && (m_tdata[39:15] != 25'd0)))
        else $error("result fields out of range");

endmodule

bind triangle_depth_rasterizer tdr_checker u_tdr_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire
